// ----- hw/rtl/hcbd_pkg.sv -----
package hcbd_pkg;

    // input item
    typedef struct packed {
        logic [1:0] action;
        logic [15:0] address;
        logic [7:0] write_data;
        logic [7:0] key_code;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] read_data;
        logic term_valid;
        logic [7:0] term_char;
        logic last;
    } t_out_item;

    // actions
    localparam logic [1:0] ACT_READ = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_KEY = 2'd2;

    // address map
    localparam int RAM_WINDOW = 32768;
    localparam logic [15:0] ADDR_PIA_LO = 16'hFE40;
    localparam logic [15:0] ADDR_PIA_HI = 16'hFE5F;
    localparam logic [15:0] ADDR_SER_STAT = 16'hFE80;
    localparam logic [15:0] ADDR_SER_DATA = 16'hFE81;
    localparam logic [15:0] ADDR_CONSOLE = 16'hFFFE;
    localparam logic [7:0] IO_PAGE = 8'hFE;

    // port register selects (low address nibble)
    localparam logic [3:0] REG_PORT_B = 4'd0;
    localparam logic [3:0] REG_PORT_A = 4'd1;
    localparam logic [3:0] REG_DIR_B = 4'd2;
    localparam logic [3:0] REG_DIR_A = 4'd3;

    localparam logic [7:0] STAT_INIT = 8'h10;
    localparam logic [7:0] STAT_RXF = 8'h08;
    localparam logic [7:0] IO_OPEN = 8'hFF;

    // console characters
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_DEL = 8'd127;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_REG,
        SRC_RAM,
        SRC_KEY
    } t_rsel;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
        logic load_out;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic [1:0] last_idx;
    } t_status;

endpackage

// ----- hw/rtl/hcbd_ctrl.sv -----
module hcbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  hcbd_pkg::t_status i_status,
    output hcbd_pkg::t_cmd    o_cmd
);
    import hcbd_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_status.clr_done) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_EMIT;
            ST_EMIT:  if (out_free && r_idx == i_status.last_idx) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.idx = r_idx;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_EXEC:  o_cmd.exec = 1'b1;
            ST_EMIT:  o_cmd.load_out = out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (o_cmd.exec) begin
            n_idx = 2'd0;
        end else if (o_cmd.load_out) begin
            n_idx = r_idx + 2'd1;
        end
        n_out_valid = o_cmd.load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hw/rtl/hcbd_dp.sv -----
module hcbd_dp #(
    parameter int RAM_DEPTH = 32768,
    parameter int KEY_DEPTH = 256,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hcbd_pkg::t_cmd      i_cmd,
    input  hcbd_pkg::t_in_item  i_in_data,
    output hcbd_pkg::t_status   o_status,
    output hcbd_pkg::t_out_item o_out_data
);
    import hcbd_pkg::*;

    localparam int RAM_AW = $clog2(RAM_DEPTH);
    localparam int KEY_AW = $clog2(KEY_DEPTH);
    localparam int COL_W = $clog2(SCREEN_COLUMNS + 1);
    localparam int RED_STEPS = $clog2((RAM_WINDOW + RAM_DEPTH - 1) / RAM_DEPTH);

    logic [7:0] r_ram_mem [RAM_DEPTH];
    logic [7:0] r_key_mem [KEY_DEPTH];
    logic [7:0] r_ram_q, r_key_q;

    t_in_item r_item;
    t_out_item r_out, n_out;

    logic [7:0] r_port_a, n_port_a, r_port_b, n_port_b;
    logic [7:0] r_dir_a, n_dir_a, r_dir_b, n_dir_b;
    logic [7:0] r_status, n_status;
    logic [KEY_AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [COL_W-1:0] r_col, n_col;
    logic [RAM_AW-1:0] r_clr_addr, n_clr_addr;

    t_rsel r_rsel, n_rsel;
    logic [7:0] r_rval, n_rval;
    logic [7:0] r_chr [3];
    logic [7:0] n_chr [3];
    logic [1:0] r_last_idx, n_last_idx;
    logic r_term, n_term;

    logic ram_we, ram_re, key_we, key_re;
    logic [RAM_AW-1:0] ram_addr, ram_index;
    logic [15:0] red;
    logic key_avail;
    logic [KEY_AW-1:0] head_inc, tail_inc;

    logic [1:0] con_cnt;
    logic [7:0] con_chr [3];
    logic [COL_W-1:0] con_col, col_inc;
    logic [7:0] rdata;

    assign key_avail = r_head != r_tail;
    assign head_inc = (r_head == KEY_AW'(KEY_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == KEY_AW'(KEY_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // ram index: address below the window reduced modulo the ram depth
    always_comb begin
        red = {1'b0, r_item.address[14:0]};
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (red >= 16'(RAM_DEPTH << k)) red = red - 16'(RAM_DEPTH << k);
        end
        ram_index = red[RAM_AW-1:0];
    end

    // console cursor
    always_comb begin
        con_cnt = 2'd0;
        con_chr = '{default: 8'h00};
        con_col = r_col;
        col_inc = r_col + 1'b1;
        if (r_item.write_data == CH_LF || r_item.write_data == CH_CR) begin
            con_col = '0;
            con_cnt = 2'd1;
            con_chr[0] = CH_LF;
        end else if (r_item.write_data == CH_BS || r_item.write_data == CH_DEL) begin
            if (r_col != '0) begin
                con_col = r_col - 1'b1;
                con_cnt = 2'd3;
                con_chr[0] = CH_BS;
                con_chr[1] = CH_SP;
                con_chr[2] = CH_BS;
            end
        end else if (r_item.write_data >= CH_SP && r_item.write_data < CH_DEL) begin
            con_chr[0] = r_item.write_data;
            if (col_inc == COL_W'(SCREEN_COLUMNS)) begin
                // column wrap
                con_col = '0;
                con_cnt = 2'd2;
                con_chr[1] = CH_LF;
            end else begin
                con_col = col_inc;
                con_cnt = 2'd1;
            end
        end
    end

    always_comb begin
        n_port_a = r_port_a;
        n_port_b = r_port_b;
        n_dir_a = r_dir_a;
        n_dir_b = r_dir_b;
        n_status = r_status;
        n_head = r_head;
        n_tail = r_tail;
        n_col = r_col;
        n_rsel = r_rsel;
        n_rval = r_rval;
        n_chr = r_chr;
        n_last_idx = r_last_idx;
        n_term = r_term;
        n_clr_addr = r_clr_addr;
        ram_we = 1'b0;
        ram_re = 1'b0;
        key_we = 1'b0;
        key_re = 1'b0;
        ram_addr = r_clr_addr;

        if (i_cmd.clear) begin
            ram_we = 1'b1;
            n_clr_addr = r_clr_addr + 1'b1;
        end

        if (i_cmd.exec) begin
            n_rsel = SRC_REG;
            n_rval = 8'h00;
            n_term = 1'b0;
            n_last_idx = 2'd0;
            n_chr = '{default: 8'h00};
            ram_addr = ram_index;
            unique case (r_item.action)
                ACT_READ: begin
                    if (!r_item.address[15]) begin
                        ram_re = 1'b1;
                        n_rsel = SRC_RAM;
                    end else if (r_item.address >= ADDR_PIA_LO
                                 && r_item.address <= ADDR_PIA_HI) begin
                        unique case (r_item.address[3:0])
                            REG_PORT_B: n_rval = r_port_b;
                            REG_PORT_A: n_rval = r_port_a;
                            REG_DIR_B:  n_rval = r_dir_b;
                            REG_DIR_A:  n_rval = r_dir_a;
                            default:    n_rval = 8'h00;
                        endcase
                    end else if (r_item.address == ADDR_SER_STAT) begin
                        n_status = key_avail ? (r_status | STAT_RXF) : (r_status & ~STAT_RXF);
                        n_rval = n_status;
                    end else if (r_item.address == ADDR_SER_DATA) begin
                        n_status = r_status & ~STAT_RXF;
                        if (key_avail) begin
                            key_re = 1'b1;
                            n_tail = tail_inc;
                            n_rsel = SRC_KEY;
                        end
                    end else if (r_item.address[15:8] == IO_PAGE) begin
                        n_rval = IO_OPEN;
                    end
                end
                ACT_WRITE: begin
                    if (!r_item.address[15]) begin
                        ram_we = 1'b1;
                    end else if (r_item.address >= ADDR_PIA_LO
                                 && r_item.address <= ADDR_PIA_HI) begin
                        unique case (r_item.address[3:0])
                            REG_PORT_B: n_port_b = r_item.write_data;
                            REG_PORT_A: n_port_a = r_item.write_data;
                            REG_DIR_B:  n_dir_b = r_item.write_data;
                            REG_DIR_A:  n_dir_a = r_item.write_data;
                            default:    n_port_a = r_port_a;
                        endcase
                    end else if (r_item.address == ADDR_SER_STAT) begin
                        n_status = r_item.write_data;
                    end else if (r_item.address == ADDR_SER_DATA
                                 || r_item.address == ADDR_CONSOLE) begin
                        n_col = con_col;
                        n_chr = con_chr;
                        if (con_cnt != 2'd0) begin
                            n_term = 1'b1;
                            n_last_idx = con_cnt - 2'd1;
                        end
                    end
                end
                ACT_KEY: begin
                    key_we = 1'b1;
                    n_head = head_inc;
                end
                default: n_term = 1'b0;
            endcase
        end
    end

    // ram and key fifo storage
    always_ff @(posedge i_clk) begin
        if (ram_we) r_ram_mem[ram_addr] <= i_cmd.clear ? 8'h00 : r_item.write_data;
        if (ram_re) r_ram_q <= r_ram_mem[ram_addr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) r_key_mem[r_head] <= r_item.key_code;
        if (key_re) r_key_q <= r_key_mem[r_tail];
    end

    always_comb begin
        unique case (r_rsel)
            SRC_RAM: rdata = r_ram_q;
            SRC_KEY: rdata = r_key_q;
            default: rdata = r_rval;
        endcase
        n_out.read_data = r_term ? 8'h00 : rdata;
        n_out.term_valid = r_term;
        n_out.term_char = r_term ? r_chr[i_cmd.idx] : 8'h00;
        n_out.last = i_cmd.idx == r_last_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a <= 8'h00;
            r_port_b <= 8'h00;
            r_dir_a <= 8'h00;
            r_dir_b <= 8'h00;
            r_status <= STAT_INIT;
            r_head <= '0;
            r_tail <= '0;
            r_col <= '0;
            r_clr_addr <= '0;
        end else begin
            r_port_a <= n_port_a;
            r_port_b <= n_port_b;
            r_dir_a <= n_dir_a;
            r_dir_b <= n_dir_b;
            r_status <= n_status;
            r_head <= n_head;
            r_tail <= n_tail;
            r_col <= n_col;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_in_data;
        if (i_cmd.load_out) r_out <= n_out;
        r_rsel <= n_rsel;
        r_rval <= n_rval;
        r_chr <= n_chr;
        r_last_idx <= n_last_idx;
        r_term <= n_term;
    end

    assign o_status.clr_done = r_clr_addr == RAM_AW'(RAM_DEPTH - 1);
    assign o_status.last_idx = r_last_idx;
    assign o_out_data = r_out;

endmodule

// ----- hw/rtl/home_computer_io_bus_decoder_core.sv -----
// Memory and I/O decoder for an emulated 8-bit home computer bus.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one bus read,
// bus write or key arrival per transfer. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns one to three result items per input;
// the final one of each input has last set.
// Flow: an accepted item is decoded in the cycle after its transfer and
// its first result is loaded into the output register in the emit state
// once that register is free; further results follow through the
// one-result-per-cycle output register while i_out_ready does not stall
// it. Console writes emit up to three characters (backspace gives 8, 32, 8).
// Reset: after i_rst_n rises the main ram is zeroed one byte per cycle,
// with o_in_ready low until every address is cleared; the port, status
// and cursor registers and the key fifo pointers reset at once. The key
// fifo has no overflow check.
// Stall: a result waits in the output register while i_out_ready is low;
// the next input is taken once the last result of the previous one is
// loaded, even while that result still waits.
module home_computer_io_bus_decoder_core #(
    parameter int RAM_DEPTH = 32768,
    parameter int KEY_DEPTH = 256,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hcbd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hcbd_pkg::t_out_item o_out_data
);
    import hcbd_pkg::*;

    t_cmd cmd;
    t_status status;

    hcbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hcbd_dp #(
        .RAM_DEPTH      (RAM_DEPTH),
        .KEY_DEPTH      (KEY_DEPTH),
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    // only console characters come in multi-result groups
    a_multi_is_console: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> o_out_data.term_valid)
        else $error("non-final result without a console character");

    // read data and console characters never share a result
    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.read_data != 8'h00)
            |-> (!o_out_data.term_valid && o_out_data.last))
        else $error("read data mixed with console output");

endmodule
